FILE: src/mwkl_pkg.sv
// Shared constants, payload types and queue sizes for the mecanum wheel kinematics limiter.
package mwkl_pkg;

   localparam int NUM_WHEELS = 4;
   localparam int IN_W       = 15;
   localparam int OUT_W      = 17;
   localparam int MAG_W      = 16;
   localparam int LIMIT_W    = 16;
   localparam int PROD_W     = MAG_W + LIMIT_W;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd49152;

   // Wheel order on every wheel vector.
   localparam int WHEEL_FR = 0;
   localparam int WHEEL_FL = 1;
   localparam int WHEEL_RL = 2;
   localparam int WHEEL_RR = 3;

   // Decoupling queue between front and back; depths are powers of two.
   localparam int MID_DEPTH = 4;
   localparam int MID_PTR_W = $clog2(MID_DEPTH);
   localparam int MID_CNT_W = $clog2(MID_DEPTH + 1);

   // Result queue at the output of the back end.
   localparam int OUT_DEPTH = 2;
   localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
   localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

   // Restoring divider: one quotient bit per step, several steps per stage.
   localparam int STEPS_PER_STAGE = 2;
   localparam int DIV_STAGES      = MAG_W / STEPS_PER_STAGE;

   typedef struct packed {
      logic [NUM_WHEELS-1:0]            neg;
      logic [NUM_WHEELS-1:0][MAG_W-1:0] mag;
      logic [LIMIT_W-1:0]               mult;
      logic [MAG_W-1:0]                 div;
      logic                             scaled;
   } cmd_type;

   typedef struct packed {
      logic [NUM_WHEELS-1:0]            neg;
      logic [NUM_WHEELS-1:0][MAG_W-1:0] rem;
      logic [NUM_WHEELS-1:0][MAG_W-1:0] dq;
      logic [MAG_W-1:0]                 div;
      logic                             scaled;
   } div_stage_type;

   typedef struct packed {
      logic [NUM_WHEELS-1:0][OUT_W-1:0] wheel;
      logic                             scaled;
   } rsp_type;

endpackage

FILE: src/mwkl_front.sv
// Front end: wheel mixing, magnitudes, peak search and scaling decision.
module mwkl_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_push,
   output logic                            req_full,
   input  logic signed [mwkl_pkg::IN_W-1:0] req_forward_speed,
   input  logic signed [mwkl_pkg::IN_W-1:0] req_side_speed,
   input  logic signed [mwkl_pkg::IN_W-1:0] req_turn_speed,
   input  logic [mwkl_pkg::LIMIT_W-1:0]    limit,
   input  logic                            q_full,
   output logic                            q_push,
   output mwkl_pkg::cmd_type               q_data
);
   import mwkl_pkg::*;

   logic                             adv;
   logic signed [OUT_W-1:0]          vx;
   logic signed [OUT_W-1:0]          vy;
   logic signed [OUT_W-1:0]          vw;
   logic signed [OUT_W-1:0]          wheel [NUM_WHEELS];
   logic                             s1_valid_ff, s1_valid_in;
   logic [NUM_WHEELS-1:0]            s1_neg_ff, s1_neg_in;
   logic [NUM_WHEELS-1:0][MAG_W-1:0] s1_mag_ff, s1_mag_in;
   logic [MAG_W-1:0]                 peak_lo, peak_hi, peak;
   logic                             s2_valid_ff, s2_valid_in;
   cmd_type                          s2_cmd_ff, s2_cmd_in;

   assign vx = OUT_W'(req_forward_speed);
   assign vy = OUT_W'(req_side_speed);
   assign vw = OUT_W'(req_turn_speed);

   assign wheel[WHEEL_FR] = -vx - vy - vw;
   assign wheel[WHEEL_FL] =  vx - vy - vw;
   assign wheel[WHEEL_RL] =  vx + vy - vw;
   assign wheel[WHEEL_RR] = -vx + vy - vw;

   // The whole front moves together; it holds only when its last stage cannot transfer.
   assign adv      = !(s2_valid_ff && q_full);
   assign req_full = !adv;

   always_comb begin
      s1_valid_in = req_push;
      for (int w = 0; w < NUM_WHEELS; w++) begin
         s1_neg_in[w] = wheel[w][OUT_W-1];
         s1_mag_in[w] = wheel[w][OUT_W-1] ? MAG_W'(-wheel[w]) : MAG_W'(wheel[w]);
      end
   end

   always_comb begin
      peak_lo = (s1_mag_ff[0] > s1_mag_ff[1]) ? s1_mag_ff[0] : s1_mag_ff[1];
      peak_hi = (s1_mag_ff[2] > s1_mag_ff[3]) ? s1_mag_ff[2] : s1_mag_ff[3];
      peak    = (peak_lo > peak_hi) ? peak_lo : peak_hi;
      s2_valid_in      = s1_valid_ff;
      s2_cmd_in.neg    = s1_neg_ff;
      s2_cmd_in.mag    = s1_mag_ff;
      s2_cmd_in.scaled = peak > limit;
      // Unscaled wheels go through the same divider as mag * peak / peak.
      s2_cmd_in.mult   = s2_cmd_in.scaled ? limit : peak;
      // An all-zero command divides zero by one.
      s2_cmd_in.div    = (peak == '0) ? MAG_W'(1) : peak;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_neg_ff <= s1_neg_in;
         s1_mag_ff <= s1_mag_in;
         s2_cmd_ff <= s2_cmd_in;
      end
   end

   assign q_push = s2_valid_ff && !q_full;
   assign q_data = s2_cmd_ff;

endmodule

FILE: src/mwkl_queue.sv
// Short command queue that decouples the front end from the back end.
module mwkl_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  mwkl_pkg::cmd_type push_data,
   output logic              full,
   input  logic              pop,
   output logic              empty,
   output mwkl_pkg::cmd_type pop_data
);
   import mwkl_pkg::*;

   cmd_type                entry_ff [MID_DEPTH];
   logic [MID_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [MID_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [MID_CNT_W-1:0]   count_ff, count_in;

   assign full     = (count_ff == MID_CNT_W'(MID_DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + MID_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + MID_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + MID_CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - MID_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: src/mwkl_back.sv
// Back end: multiply by the scale factor, pipelined restoring divide and result queue.
module mwkl_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_empty,
   input  mwkl_pkg::cmd_type q_data,
   output logic              q_pop,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output mwkl_pkg::rsp_type rsp_data
);
   import mwkl_pkg::*;

   // One restoring step: shifts the next dividend bit into the remainder.
   function automatic logic [2*MAG_W-1:0] div_step(input logic [MAG_W-1:0] rem,
                                                   input logic [MAG_W-1:0] dq,
                                                   input logic [MAG_W-1:0] div);
      logic [MAG_W:0] trial;
      trial = {rem, dq[MAG_W-1]};
      if (trial >= {1'b0, div}) begin
         return {MAG_W'(trial - {1'b0, div}), dq[MAG_W-2:0], 1'b1};
      end
      return {trial[MAG_W-1:0], dq[MAG_W-2:0], 1'b0};
   endfunction

   logic                    adv;
   logic                    out_full;
   logic                    out_push;
   logic                    out_pop;
   logic [PROD_W-1:0]       prod [NUM_WHEELS];
   logic [DIV_STAGES:0]     valid_ff, valid_in;
   div_stage_type           stage_ff [DIV_STAGES+1];
   div_stage_type           stage_in [DIV_STAGES+1];
   rsp_type                 result;
   rsp_type                 out_ff [OUT_DEPTH];
   logic [OUT_PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [OUT_PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [OUT_CNT_W-1:0]    count_ff, count_in;

   assign out_full = (count_ff == OUT_CNT_W'(OUT_DEPTH));
   assign adv      = !(valid_ff[DIV_STAGES] && out_full);
   assign q_pop    = adv && !q_empty;
   assign valid_in = {valid_ff[DIV_STAGES-1:0], q_pop};

   always_comb begin
      stage_in[0].neg    = q_data.neg;
      stage_in[0].div    = q_data.div;
      stage_in[0].scaled = q_data.scaled;
      for (int w = 0; w < NUM_WHEELS; w++) begin
         prod[w] = q_data.mag[w] * q_data.mult;
         // The quotient fits in MAG_W bits, so the upper half is already below the divisor.
         stage_in[0].rem[w] = prod[w][PROD_W-1:MAG_W];
         stage_in[0].dq[w]  = prod[w][MAG_W-1:0];
      end
      for (int k = 1; k <= DIV_STAGES; k++) begin
         stage_in[k] = stage_ff[k-1];
         for (int s = 0; s < STEPS_PER_STAGE; s++) begin
            for (int w = 0; w < NUM_WHEELS; w++) begin
               {stage_in[k].rem[w], stage_in[k].dq[w]} =
                  div_step(stage_in[k].rem[w], stage_in[k].dq[w], stage_in[k].div);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k <= DIV_STAGES; k++) begin
            stage_ff[k] <= stage_in[k];
         end
      end
   end

   always_comb begin
      for (int w = 0; w < NUM_WHEELS; w++) begin
         result.wheel[w] = stage_ff[DIV_STAGES].neg[w]
                         ? OUT_W'(0) - {1'b0, stage_ff[DIV_STAGES].dq[w]}
                         : {1'b0, stage_ff[DIV_STAGES].dq[w]};
      end
      result.scaled = stage_ff[DIV_STAGES].scaled;
   end

   assign out_push  = valid_ff[DIV_STAGES] && !out_full;
   assign rsp_empty = (count_ff == '0);
   assign out_pop   = rsp_pop && !rsp_empty;
   assign rsp_data  = out_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = out_push ? wr_ptr_ff + OUT_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = out_pop  ? rd_ptr_ff + OUT_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (out_push && !out_pop) begin
         count_in = count_ff + OUT_CNT_W'(1);
      end else if (out_pop && !out_push) begin
         count_in = count_ff - OUT_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_push) begin
         out_ff[wr_ptr_ff] <= result;
      end
   end

endmodule

FILE: src/mecanum_wheel_kinematics_limit.sv
// A command moves through the front stages, command queue, multiply stage, divider and result queue.
// Throughput: one command per cycle unless results back up; the 8-stage divider (2 quotient bits
// per stage per wheel) and the 4-entry command queue between front and back keep every stage busy.
// Stalls on the result side fill the 2-entry result queue, then the command queue, then raise full.
// Reset is synchronous and active high: it empties both queues and the pipelines,
// and sets the wheel speed limit to 49152.
module mecanum_wheel_kinematics_limit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_push,
   output logic                               req_full,
   input  logic signed [mwkl_pkg::IN_W-1:0]   req_forward_speed,
   input  logic signed [mwkl_pkg::IN_W-1:0]   req_side_speed,
   input  logic signed [mwkl_pkg::IN_W-1:0]   req_turn_speed,
   output logic                               rsp_empty,
   input  logic                               rsp_pop,
   output logic signed [mwkl_pkg::OUT_W-1:0]  rsp_front_right_speed,
   output logic signed [mwkl_pkg::OUT_W-1:0]  rsp_front_left_speed,
   output logic signed [mwkl_pkg::OUT_W-1:0]  rsp_rear_left_speed,
   output logic signed [mwkl_pkg::OUT_W-1:0]  rsp_rear_right_speed,
   output logic                               rsp_was_scaled,
   input  logic                               csr_write_en,
   input  logic [mwkl_pkg::LIMIT_W-1:0]       csr_write_data
);
   import mwkl_pkg::*;

   logic [LIMIT_W-1:0] limit_ff, limit_in;
   logic               q_push;
   logic               q_full;
   logic               q_pop;
   logic               q_empty;
   cmd_type            q_push_data;
   cmd_type            q_pop_data;
   rsp_type            rsp_data;

   assign limit_in = csr_write_en ? csr_write_data : limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else begin
         limit_ff <= limit_in;
      end
   end

   mwkl_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_forward_speed (req_forward_speed),
      .req_side_speed    (req_side_speed),
      .req_turn_speed    (req_turn_speed),
      .limit             (limit_ff),
      .q_full            (q_full),
      .q_push            (q_push),
      .q_data            (q_push_data)
   );

   mwkl_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .full      (q_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .pop_data  (q_pop_data)
   );

   mwkl_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_data    (q_pop_data),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   assign rsp_front_right_speed = rsp_data.wheel[WHEEL_FR];
   assign rsp_front_left_speed  = rsp_data.wheel[WHEEL_FL];
   assign rsp_rear_left_speed   = rsp_data.wheel[WHEEL_RL];
   assign rsp_rear_right_speed  = rsp_data.wheel[WHEEL_RR];
   assign rsp_was_scaled        = rsp_data.scaled;

`ifndef SYNTHESIS
   // After reset nothing waits on the result side and commands can be transferred.
   a_reset_clears: assert property (@(posedge clock)
      reset |=> (rsp_empty && !req_full))
      else $error("pipeline not cleared by reset");

   // Scaling only ever happens below the largest reachable peak.
   a_scaled_limit: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_was_scaled) |-> (limit_ff < LIMIT_RESET))
      else $error("scaled result with a limit that no peak can exceed");

   // The front-right and rear-left wheels of a scaled result never exceed the limit in magnitude.
   a_scaled_bound: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_was_scaled) |->
         (($signed(rsp_front_right_speed) <= $signed({1'b0, limit_ff})) &&
          ($signed(rsp_front_right_speed) >= -$signed({1'b0, limit_ff})) &&
          ($signed(rsp_rear_left_speed) <= $signed({1'b0, limit_ff})) &&
          ($signed(rsp_rear_left_speed) >= -$signed({1'b0, limit_ff}))))
      else $error("scaled wheel speed above limit");
`endif

endmodule

FILE: bench/mecanum_wheel_kinematics_limit_tb.sv
// Self-checking testbench for the mecanum wheel kinematics limiter with a wheel-speed predictor.
`timescale 1ns / 100ps

module mecanum_wheel_kinematics_limit_tb;
   import mwkl_pkg::*;

   localparam int TIMEOUT_CYCLES = 400000;
   localparam int SETTLE_CYCLES  = 30;
   localparam int RANDOM_PHASES  = 10;
   localparam int PHASE_ITEMS    = 145;

   typedef struct {
      logic signed [IN_W-1:0] vx;
      logic signed [IN_W-1:0] vy;
      logic signed [IN_W-1:0] vw;
   } speed_cmd_type;

   typedef struct {
      logic signed [OUT_W-1:0] front_right;
      logic signed [OUT_W-1:0] front_left;
      logic signed [OUT_W-1:0] rear_left;
      logic signed [OUT_W-1:0] rear_right;
      logic                    scaled;
   } wheel_set_type;

   logic                      clock;
   logic                      reset = 1'b1;
   logic                      req_push = 1'b0;
   logic                      req_full;
   logic signed [IN_W-1:0]    req_forward_speed = '0;
   logic signed [IN_W-1:0]    req_side_speed = '0;
   logic signed [IN_W-1:0]    req_turn_speed = '0;
   logic                      rsp_empty;
   logic                      rsp_pop = 1'b0;
   logic signed [OUT_W-1:0]   rsp_front_right_speed;
   logic signed [OUT_W-1:0]   rsp_front_left_speed;
   logic signed [OUT_W-1:0]   rsp_rear_left_speed;
   logic signed [OUT_W-1:0]   rsp_rear_right_speed;
   logic                      rsp_was_scaled;
   logic                      csr_write_en = 1'b0;
   logic [LIMIT_W-1:0]        csr_write_data = '0;

   speed_cmd_type  queued_commands[$];
   wheel_set_type  expected_wheels[$];
   logic [LIMIT_W-1:0] speed_limit = LIMIT_RESET;
   logic           stalls_on = 1'b1;
   logic           cmd_taken = 1'b0;
   int unsigned    cmd_gap = 0;
   int unsigned    rsp_gap = 0;
   int unsigned    error_count = 0;
   int unsigned    cycle_count = 0;

   mecanum_wheel_kinematics_limit dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_push              (req_push),
      .req_full              (req_full),
      .req_forward_speed     (req_forward_speed),
      .req_side_speed        (req_side_speed),
      .req_turn_speed        (req_turn_speed),
      .rsp_empty             (rsp_empty),
      .rsp_pop               (rsp_pop),
      .rsp_front_right_speed (rsp_front_right_speed),
      .rsp_front_left_speed  (rsp_front_left_speed),
      .rsp_rear_left_speed   (rsp_rear_left_speed),
      .rsp_rear_right_speed  (rsp_rear_right_speed),
      .rsp_was_scaled        (rsp_was_scaled),
      .csr_write_en          (csr_write_en),
      .csr_write_data        (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Wheel speeds for one command, scaled down in proportion when the peak is above the limit.
   function automatic wheel_set_type limit_wheel_speeds(input speed_cmd_type cmd,
                                                        input logic [LIMIT_W-1:0] limit);
      longint        w[4];
      longint        fx, sy, tw, mag, peak, lim, q;
      wheel_set_type r;
      fx = longint'(cmd.vx);
      sy = longint'(cmd.vy);
      tw = longint'(cmd.vw);
      lim = longint'(limit);
      w[0] = -fx - sy - tw;
      w[1] =  fx - sy - tw;
      w[2] =  fx + sy - tw;
      w[3] = -fx + sy - tw;
      peak = 0;
      for (int i = 0; i < 4; i++) begin
         mag = (w[i] < 0) ? -w[i] : w[i];
         if (mag > peak) peak = mag;
      end
      r.scaled = (peak > lim);
      if (r.scaled) begin
         for (int i = 0; i < 4; i++) begin
            mag = (w[i] < 0) ? -w[i] : w[i];
            q = (mag * lim) / peak;
            w[i] = (w[i] < 0) ? -q : q;
         end
      end
      r.front_right = OUT_W'(w[0]);
      r.front_left  = OUT_W'(w[1]);
      r.rear_left   = OUT_W'(w[2]);
      r.rear_right  = OUT_W'(w[3]);
      return r;
   endfunction

   function automatic logic signed [IN_W-1:0] corner_speed();
      case ($urandom_range(0, 4))
         0: return -IN_W'(16384);
         1: return IN_W'(16383);
         2: return '0;
         3: return IN_W'(1);
         default: return -IN_W'(1);
      endcase
   endfunction

   function automatic speed_cmd_type random_command();
      speed_cmd_type c;
      int unsigned   mode;
      mode = $urandom_range(0, 9);
      if (mode < 5) begin
         c.vx = IN_W'($urandom);
         c.vy = IN_W'($urandom);
         c.vw = IN_W'($urandom);
      end else if (mode < 8) begin
         c.vx = IN_W'(int'($urandom_range(0, 600)) - 300);
         c.vy = IN_W'(int'($urandom_range(0, 600)) - 300);
         c.vw = IN_W'(int'($urandom_range(0, 600)) - 300);
      end else begin
         c.vx = corner_speed();
         c.vy = corner_speed();
         c.vw = corner_speed();
      end
      return c;
   endfunction

   task automatic queue_command(input int vx, input int vy, input int vw);
      speed_cmd_type c;
      c.vx = IN_W'(vx);
      c.vy = IN_W'(vy);
      c.vw = IN_W'(vw);
      queued_commands.push_back(c);
   endtask

   // Waits until every command has gone in and every result has come out.
   task automatic wait_drained();
      while (queued_commands.size() != 0 || expected_wheels.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_limit(input logic [LIMIT_W-1:0] value);
      wait_drained();
      @(negedge clock);
      csr_write_en   <= 1'b1;
      csr_write_data <= value;
      speed_limit = value;
      @(negedge clock);
      csr_write_en   <= 1'b0;
   endtask

   task automatic check_field(input string name, input logic signed [OUT_W-1:0] want,
                              input logic signed [OUT_W-1:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %0d got %0d", $time, name, want, got);
         error_count++;
      end
   endtask

   // Command side: a held transfer stays on the bus until the block takes it.
   always @(negedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
         cmd_gap  <= 0;
      end else if (req_push && !cmd_taken) begin
         req_push <= 1'b1;
      end else if (cmd_gap > 0) begin
         req_push <= 1'b0;
         cmd_gap  <= cmd_gap - 1;
      end else if (stalls_on && $urandom_range(0, 5) == 0) begin
         req_push <= 1'b0;
         cmd_gap  <= $urandom_range(0, 7);
      end else if (queued_commands.size() > 0) begin
         req_push          <= 1'b1;
         req_forward_speed <= queued_commands[0].vx;
         req_side_speed    <= queued_commands[0].vy;
         req_turn_speed    <= queued_commands[0].vw;
      end else begin
         req_push <= 1'b0;
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
         rsp_gap <= 0;
      end else if (rsp_gap > 0) begin
         rsp_pop <= 1'b0;
         rsp_gap <= rsp_gap - 1;
      end else if (stalls_on && $urandom_range(0, 5) == 0) begin
         rsp_pop <= 1'b0;
         rsp_gap <= $urandom_range(0, 7);
      end else begin
         rsp_pop <= 1'b1;
      end
   end

   // Both transfers are seen at the rising edge, before the block's own updates land.
   always @(posedge clock) begin
      if (reset) begin
         cmd_taken <= 1'b0;
      end else begin
         cmd_taken <= req_push && !req_full;
         if (req_push && !req_full) begin
            expected_wheels.push_back(limit_wheel_speeds(queued_commands[0], speed_limit));
            void'(queued_commands.pop_front());
         end
         if (rsp_pop && !rsp_empty) begin
            if (expected_wheels.size() == 0) begin
               $display("%0t: result with none expected: fr %0d fl %0d rl %0d rr %0d scaled %0d",
                        $time, rsp_front_right_speed, rsp_front_left_speed,
                        rsp_rear_left_speed, rsp_rear_right_speed, rsp_was_scaled);
               error_count++;
            end else begin
               check_field("front_right_speed", expected_wheels[0].front_right,
                           rsp_front_right_speed);
               check_field("front_left_speed", expected_wheels[0].front_left,
                           rsp_front_left_speed);
               check_field("rear_left_speed", expected_wheels[0].rear_left,
                           rsp_rear_left_speed);
               check_field("rear_right_speed", expected_wheels[0].rear_right,
                           rsp_rear_right_speed);
               check_field("was_scaled", OUT_W'(expected_wheels[0].scaled),
                           OUT_W'(rsp_was_scaled));
               void'(expected_wheels.pop_front());
            end
         end
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   initial begin
      while (cycle_count < TIMEOUT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      logic [LIMIT_W-1:0] next_limit;
      wait (reset == 1'b0);

      // Limit as it comes out of reset: the largest command just reaches it.
      queue_command(0, 0, 0);
      queue_command(16383, 16383, 16383);
      queue_command(-16384, -16384, -16384);
      queue_command(-16384, 16383, -16384);
      queue_command(16383, -16384, 0);
      queue_command(1, 0, 0);
      queue_command(0, 1, 0);
      queue_command(0, 0, -1);

      // A zero limit forces every wheel to zero unless the command is already still.
      write_limit('0);
      queue_command(0, 0, 0);
      queue_command(5, -3, 2);
      queue_command(-16384, 16383, 16383);

      // Peak equal to the limit passes unchanged; one above it is scaled.
      write_limit(LIMIT_W'(100));
      queue_command(100, 0, 0);
      queue_command(0, 0, -100);
      queue_command(101, 0, 0);
      queue_command(40, 30, 31);
      queue_command(-50, -25, -26);

      write_limit(LIMIT_W'(65535));
      queue_command(-16384, -16384, -16384);
      queue_command(16383, -16384, 16383);

      write_limit(LIMIT_W'(1));
      queue_command(1, -1, 1);
      queue_command(16383, 7, -16384);

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            0: next_limit = LIMIT_RESET;
            1: next_limit = '0;
            2: next_limit = LIMIT_W'(65535);
            3: next_limit = LIMIT_W'(1);
            4, 5, 6: next_limit = LIMIT_W'($urandom_range(1000, 49152));
            default: next_limit = LIMIT_W'($urandom);
         endcase
         write_limit(next_limit);
         // Some phases run with neither side idling, the last one among them.
         stalls_on = (p % 4 != 3) && (p != RANDOM_PHASES - 1);
         for (int i = 0; i < PHASE_ITEMS; i++)
            queued_commands.push_back(random_command());
      end

      wait_drained();
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
